// ===== hw/rtl/cvs_pkg.sv =====
package cvs_pkg;

	localparam int CELL_COUNT_MAX_DEF = 24;
	localparam int CELL_W = 5;
	localparam int MV_W = 16;
	localparam int CUR_W = 20;
	localparam int COEF_W = 16;
	localparam int PROD_W = CUR_W + COEF_W;
	localparam int WEIGHT_W = 17;
	localparam int TOTAL_W = 21;
	localparam int COEF_REGS = 6;
	localparam int CFG_DATA_W = 64;
	localparam int REG_ADDR_W = 6;
	localparam int REG_IDX_W = 3;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
	localparam logic [MV_W-1:0] MIN_INIT = 16'hffff;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WEIGHT,
		REG_COEF_0_3,
		REG_COEF_4_7,
		REG_COEF_8_11,
		REG_COEF_12_15,
		REG_COEF_16_19,
		REG_COEF_20_23,
		REG_NONE
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SAG,
		ST_COMP,
		ST_MUL,
		ST_FIN
	} state_t;

endpackage

// ===== hw/rtl/cvs_if.sv =====
interface cvs_sample_if;
	logic                            valid;
	logic                            ready;
	logic [cvs_pkg::CELL_W-1:0]      cell_index;
	logic [cvs_pkg::MV_W-1:0]        raw_cell_mv;
	logic signed [cvs_pkg::CUR_W-1:0] current_ma;
	logic                            last_cell;

	modport source (output valid, cell_index, raw_cell_mv, current_ma, last_cell, input ready);
	modport sink (input valid, cell_index, raw_cell_mv, current_ma, last_cell, output ready);
endinterface

interface cvs_result_if;
	logic                          valid;
	logic                          ready;
	logic [cvs_pkg::MV_W-1:0]      filtered_mv;
	logic [cvs_pkg::MV_W-1:0]      pass_min_mv;
	logic [cvs_pkg::MV_W-1:0]      pass_max_mv;
	logic [cvs_pkg::TOTAL_W-1:0]   pass_total_mv;
	logic                          pass_done;

	modport source (output valid, filtered_mv, pass_min_mv, pass_max_mv, pass_total_mv,
		pass_done, input ready);
	modport sink (input valid, filtered_mv, pass_min_mv, pass_max_mv, pass_total_mv,
		pass_done, output ready);
endinterface

// ===== hw/rtl/cell_voltage_sag_comp_smoother.sv =====
// Cell voltage sag compensation and smoothing.
// sample channel: one cell reading per transaction (cell index, raw mV,
// pack current in mA, last-cell mark). result channel: one transaction per
// reading with the filtered voltage and the running min, max and total of
// the pass; pass_done repeats the last-cell mark.
// APB port: register i at byte address 8*i, 64-bit data, pready always high.
// Each accepted reading passes through sag multiply, compensation and
// history read, blend multiply and finish; its result is loaded into the
// output register in the finish cycle, and the next reading is taken only
// in that cycle or while idle, not before the current one is through.
// The history memory is written in the finish cycle and read in the cycle
// after the next acceptance, so consecutive readings of one cell need no
// forwarding.
// If the receiver stalls, the result waits in the output register and the
// block holds in the finish cycle until that register is taken.
// Reset clears the pass statistics, the seeded flag and the registers
// (weight 65536, coefficients 0); history is rebuilt during the first pass.
module cell_voltage_sag_comp_smoother #(
	parameter int CELL_COUNT_MAX = cvs_pkg::CELL_COUNT_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	cvs_sample_if.sink                        sample,
	cvs_result_if.source                      result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cvs_pkg::REG_ADDR_W-1:0]    paddr,
	input  logic [cvs_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [cvs_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import cvs_pkg::*;

	localparam int ADDR_W = (CELL_COUNT_MAX > 1) ? $clog2(CELL_COUNT_MAX) : 1;

	// configuration
	logic [WEIGHT_W-1:0]   weight_q;
	logic [CFG_DATA_W-1:0] coef_q [COEF_REGS];
	reg_idx_t              reg_idx;
	logic                  cfg_wr;
	logic                  idx_is_coef;
	logic [REG_IDX_W-1:0]  coef_slot;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[REG_ADDR_W-1:3]);
	assign idx_is_coef = (reg_idx >= REG_COEF_0_3) && (reg_idx <= REG_COEF_20_23);
	assign coef_slot = reg_idx - REG_COEF_0_3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_ONE;
			for (int i = 0; i < COEF_REGS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			if (reg_idx == REG_WEIGHT) begin
				weight_q <= pwdata[WEIGHT_W-1:0];
			end else if (idx_is_coef) begin
				coef_q[coef_slot] <= pwdata;
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_WEIGHT) begin
			prdata = CFG_DATA_W'(weight_q);
		end else if (idx_is_coef) begin
			prdata = coef_q[coef_slot];
		end
	end

	// control
	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   take;
	logic   ram_we;
	logic   ram_re;
	logic   load_out;

	assign out_free = !out_valid_q || result.ready;
	assign take = sample.valid && sample.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (take) state_d = ST_SAG;
			ST_SAG:  state_d = ST_COMP;
			ST_COMP: state_d = ST_MUL;
			ST_MUL:  state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = take ? ST_SAG : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = 1'b0;
		ram_re = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: sample.ready = 1'b1;
			ST_SAG:  ram_re = 1'b1;
			ST_FIN: begin
				sample.ready = out_free;
				load_out = out_free;
			end
			default: ;
		endcase
	end

	// item registers
	logic [CELL_W-1:0]       cell_q;
	logic [MV_W-1:0]         raw_q;
	logic signed [CUR_W-1:0] cur_q;
	logic                    last_q;
	logic                    in_range;

	assign in_range = 32'(cell_q) < CELL_COUNT_MAX;

	always_ff @(posedge clk) begin
		if (take) begin
			cell_q <= sample.cell_index;
			raw_q <= sample.raw_cell_mv;
			cur_q <= sample.current_ma;
			last_q <= sample.last_cell;
		end
	end

	// sag multiply
	logic [CFG_DATA_W-1:0]    coef_word;
	logic signed [COEF_W-1:0] coef_sel;
	logic signed [PROD_W-1:0] prod_s1;

	always_comb begin
		coef_word = '0;
		if (32'(cell_q[CELL_W-1:2]) < COEF_REGS) begin
			coef_word = coef_q[cell_q[CELL_W-1:2]];
		end
		coef_sel = in_range ? coef_word[16*cell_q[1:0] +: COEF_W] : '0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SAG) begin
			prod_s1 <= PROD_W'(cur_q) * PROD_W'(coef_sel);
		end
	end

	// compensation and history select
	logic [MV_W-1:0] hist_rdata;
	logic [MV_W-1:0] comp;
	logic [MV_W-1:0] comp_s2;
	logic [MV_W-1:0] prev_s2;
	logic            seeded_q;
	logic            round_up;

	// truncation toward zero for a negative product with a fraction
	assign round_up = prod_s1[PROD_W-1] && (prod_s1[15:0] != '0);
	assign comp = raw_q + prod_s1[31:16] + MV_W'(round_up);

	always_ff @(posedge clk) begin
		if (state_q == ST_COMP) begin
			comp_s2 <= comp;
			prev_s2 <= (in_range && seeded_q) ? hist_rdata : comp;
		end
	end

	// blend multiply
	logic [WEIGHT_W-1:0] w_eff;
	logic [WEIGHT_W-1:0] w_rest;
	logic [32:0]         new_prod;
	logic [32:0]         old_prod;
	logic [MV_W-1:0]     new_s3;
	logic [MV_W-1:0]     old_s3;

	assign w_eff = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign w_rest = WEIGHT_ONE - w_eff;
	assign new_prod = 33'(comp_s2) * 33'(w_eff);
	assign old_prod = 33'(prev_s2) * 33'(w_rest);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			new_s3 <= new_prod[31:16];
			old_s3 <= old_prod[31:16];
		end
	end

	// finish: filtered value and pass statistics
	logic [MV_W-1:0]    filt;
	logic [MV_W-1:0]    min_q, max_q, min_d, max_d;
	logic [TOTAL_W-1:0] total_q, total_d;

	assign filt = new_s3 + old_s3;
	assign min_d = (filt < min_q) ? filt : min_q;
	assign max_d = (filt > max_q) ? filt : max_q;
	assign total_d = total_q + TOTAL_W'(filt);
	assign ram_we = load_out && in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			seeded_q <= 1'b0;
			min_q <= MIN_INIT;
			max_q <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					seeded_q <= 1'b1;
					min_q <= MIN_INIT;
					max_q <= '0;
					total_q <= '0;
				end else begin
					min_q <= min_d;
					max_q <= max_d;
					total_q <= total_d;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic [MV_W-1:0]    out_filt_q, out_min_q, out_max_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               out_done_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_filt_q <= filt;
			out_min_q <= min_d;
			out_max_q <= max_d;
			out_total_q <= total_d;
			out_done_q <= last_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.filtered_mv = out_filt_q;
	assign result.pass_min_mv = out_min_q;
	assign result.pass_max_mv = out_max_q;
	assign result.pass_total_mv = out_total_q;
	assign result.pass_done = out_done_q;

	cvs_ram #(
		.WIDTH (MV_W),
		.DEPTH (CELL_COUNT_MAX),
		.ADDR_W(ADDR_W)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cell_q[ADDR_W-1:0]),
		.wdata(filt),
		.re   (ram_re),
		.raddr(cell_q[ADDR_W-1:0]),
		.rdata(hist_rdata)
	);
endmodule

// ===== hw/rtl/cvs_ram.sv =====
module cvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 24,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
